[rtl/core/arlc_pkg.sv]
package arlc_pkg;

  localparam int WinDepth = 14;
  localparam int NumKw = 5;
  localparam int LineMax = 128;
  localparam int LenW = 8;
  localparam int ClassW = 3;

  localparam logic [7:0] ChLf = 8'd10;
  localparam logic [7:0] ChCr = 8'd13;

  typedef logic [7:0] char_t;
  typedef char_t [WinDepth-1:0] window_t;
  typedef logic [NumKw-1:0] hits_t;

  localparam int KwOk = 0;
  localparam int KwGot = 1;
  localparam int KwWifi = 2;
  localparam int KwConn = 3;
  localparam int KwIpd = 4;

  typedef enum logic [ClassW-1:0] {
    CLS_WAIT = 3'd0,
    CLS_OK   = 3'd1,
    CLS_GOT  = 3'd2,
    CLS_WIFI = 3'd3,
    CLS_CONN = 3'd4,
    CLS_IPD  = 3'd5
  } line_class_t;

  typedef struct packed {
    logic        valid;
    line_class_t line_class;
    logic        line_overflow;
  } result_t;

  function automatic line_class_t pick_class(hits_t h);
    line_class_t c;
    if (h[KwGot]) c = CLS_GOT;
    else if (h[KwOk]) c = CLS_OK;
    else if (h[KwWifi]) c = CLS_WIFI;
    else if (h[KwConn]) c = CLS_CONN;
    else if (h[KwIpd]) c = CLS_IPD;
    else c = CLS_WAIT;
    return c;
  endfunction

endpackage

[rtl/core/arlc_match.sv]
module arlc_match (
  input  arlc_pkg::window_t win,
  input  arlc_pkg::char_t   c,
  output arlc_pkg::hits_t   hits
);

  localparam logic [15*8-1:0] KwWifiTxt = "WIFI DISCONNECT";
  localparam logic [7*8-1:0]  KwConnTxt = "CONNECT";
  localparam logic [3*8-1:0]  KwGotTxt  = "GOT";
  localparam logic [3*8-1:0]  KwIpdTxt  = "IPD";
  localparam logic [2*8-1:0]  KwOkTxt   = "OK";

  // window with the new char at the bottom: seq[0] newest
  logic [(arlc_pkg::WinDepth+1)*8-1:0] seq;

  assign seq = {win, c};

  assign hits[arlc_pkg::KwOk]   = (seq[2*8-1:0] == KwOkTxt);
  assign hits[arlc_pkg::KwGot]  = (seq[3*8-1:0] == KwGotTxt);
  assign hits[arlc_pkg::KwWifi] = (seq[15*8-1:0] == KwWifiTxt);
  assign hits[arlc_pkg::KwConn] = (seq[7*8-1:0] == KwConnTxt);
  assign hits[arlc_pkg::KwIpd]  = (seq[3*8-1:0] == KwIpdTxt);

endmodule

[rtl/core/arlc_line.sv]
module arlc_line (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  arlc_pkg::char_t  c,
  output arlc_pkg::result_t res
);

  arlc_pkg::window_t          win_r, win_nxt;
  arlc_pkg::hits_t            hits_r, hits_nxt, hit_now;
  logic [arlc_pkg::LenW-1:0]  len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;

  arlc_match u_match (
    .win  (win_r),
    .c    (c),
    .hits (hit_now)
  );

  always_comb begin
    win_nxt  = win_r;
    hits_nxt = hits_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    res.valid         = 1'b0;
    res.line_class    = arlc_pkg::pick_class(hits_r);
    res.line_overflow = ovf_r;
    if (take && c != arlc_pkg::ChCr) begin
      if (c == arlc_pkg::ChLf) begin
        res.valid = 1'b1;
        win_nxt   = '0;
        hits_nxt  = '0;
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        hits_nxt = hits_r | hit_now;
        win_nxt  = {win_r[arlc_pkg::WinDepth-2:0], c};
        if (len_r < arlc_pkg::LenW'(arlc_pkg::LineMax)) len_nxt = len_r + 1'b1;
        else ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      hits_r <= '0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      hits_r <= hits_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= arlc_pkg::LenW'(arlc_pkg::LineMax))
    else $error("line length above limit");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> len_r == arlc_pkg::LenW'(arlc_pkg::LineMax))
    else $error("overflow without full length");
  a_lf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> hits_r == '0 && len_r == '0 && !ovf_r)
    else $error("line state not cleared");
  a_wifi_conn: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r[arlc_pkg::KwWifi] |-> hits_r[arlc_pkg::KwConn])
    else $error("wifi disconnect without connect");

endmodule

[rtl/core/at_reply_line_classifier.sv]
// channel | ports                        | word
// in      | in_valid, in_stall, in_rx_byte | one received byte
// out     | out_valid, out_stall, out_line_class, out_line_overflow | one line result
// A byte is taken every cycle while in_valid is high and in_stall is low; the line state updates in the same cycle.
// A line feed's result appears in the output register in the cycle after the line feed is taken.
// in_stall is high only while the output register is full and stalled.
// Reset (rst_n low, synchronous) clears window, flags, length and out_valid.
module at_reply_line_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_line_class,
  output logic       out_line_overflow
);

  arlc_pkg::result_t res;
  logic              take;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        cls_r;
  logic              ovf_r;

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  arlc_line u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .c     (in_rx_byte),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_stall) out_valid_nxt = 1'b0;
    if (res.valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      cls_r <= res.line_class;
      ovf_r <= res.line_overflow;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_line_class    = cls_r;
  assign out_line_overflow = ovf_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !(out_valid_r && out_stall))
    else $error("result over a held one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(cls_r) && $stable(ovf_r))
    else $error("held result changed");
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> cls_r <= arlc_pkg::CLS_IPD)
    else $error("bad class");

endmodule

[tb/at_reply_line_classifier_tb.sv]
module at_reply_line_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int RandWords = 650;
  localparam int StallCap = 12;

  typedef struct {
    arlc_pkg::line_class_t cls;
    logic                  ovf;
  } line_result_t;

  typedef struct {
    string                 text;
    int                    pad_n;
    arlc_pkg::char_t       pad_c;
    bit                    typed;
    arlc_pkg::line_class_t cls;
    logic                  ovf;
  } line_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_line_class;
  logic       out_line_overflow;

  at_reply_line_classifier u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_class   (out_line_class),
    .out_line_overflow(out_line_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line state mirror
  arlc_pkg::char_t line_win [arlc_pkg::WinDepth];
  arlc_pkg::hits_t line_hits;
  logic [7:0]      line_len;
  logic            line_ovf;
  string           kw_text [arlc_pkg::NumKw];

  line_result_t expected_lines [$];
  line_row_t    dir_rows [$];
  line_result_t pinned;
  bit           pin_on = 1'b0;

  bit active = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;
  int words_taken = 0;
  int lines_checked = 0;
  int ovf_lines = 0;
  int class_seen [6];
  int burst_left = 0;

  function automatic void clear_line();
    for (int i = 0; i < arlc_pkg::WinDepth; i++) line_win[i] = 8'h00;
    line_hits = '0;
    line_len = 8'd0;
    line_ovf = 1'b0;
  endfunction

  function automatic bit ends_keyword(int k, arlc_pkg::char_t c);
    int n;
    n = kw_text[k].len();
    if (c != arlc_pkg::char_t'(kw_text[k][n-1])) return 1'b0;
    for (int i = 1; i < n; i++)
      if (line_win[i-1] != arlc_pkg::char_t'(kw_text[k][n-1-i])) return 1'b0;
    return 1'b1;
  endfunction

  // advances the line state by one word (a CR is ignored); returns 1 when a line result is due
  function automatic bit classify_byte(arlc_pkg::char_t c, output line_result_t r);
    r.cls = arlc_pkg::CLS_WAIT;
    r.ovf = 1'b0;
    if (c == arlc_pkg::ChCr) return 1'b0;
    if (c == arlc_pkg::ChLf) begin
      if (line_hits[arlc_pkg::KwGot]) r.cls = arlc_pkg::CLS_GOT;
      else if (line_hits[arlc_pkg::KwOk]) r.cls = arlc_pkg::CLS_OK;
      else if (line_hits[arlc_pkg::KwWifi]) r.cls = arlc_pkg::CLS_WIFI;
      else if (line_hits[arlc_pkg::KwConn]) r.cls = arlc_pkg::CLS_CONN;
      else if (line_hits[arlc_pkg::KwIpd]) r.cls = arlc_pkg::CLS_IPD;
      r.ovf = line_ovf;
      clear_line();
      return 1'b1;
    end
    for (int k = 0; k < arlc_pkg::NumKw; k++)
      if (ends_keyword(k, c)) line_hits[k] = 1'b1;
    for (int i = arlc_pkg::WinDepth - 1; i > 0; i--) line_win[i] = line_win[i-1];
    line_win[0] = c;
    if (line_len < arlc_pkg::LineMax) line_len = line_len + 8'd1;
    else line_ovf = 1'b1;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    line_result_t r;
    line_result_t e;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        words_taken++;
        if (classify_byte(in_rx_byte, r)) begin
          if (pin_on) expected_lines.push_back(pinned);
          else expected_lines.push_back(r);
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_lines.size() == 0) begin
          errors++;
          $display("%0t: unexpected line result class=%0d ovf=%0b", $time,
                   out_line_class, out_line_overflow);
        end else begin
          e = expected_lines.pop_front();
          lines_checked++;
          class_seen[int'(e.cls)]++;
          if (e.ovf) ovf_lines++;
          if (out_line_class !== e.cls) begin
            errors++;
            $display("%0t: line_class expected %0d (%s) actual %0d", $time,
                     e.cls, e.cls.name(), out_line_class);
          end
          if (out_line_overflow !== e.ovf) begin
            errors++;
            $display("%0t: line_overflow expected %0b actual %0b", $time,
                     e.ovf, out_line_overflow);
          end
        end
      end
    end
    if (active) begin
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: stall pattern drawn from one of four modes, redrawn at random
  initial begin
    int mode;
    int mode_left;
    int phase;
    int stall_run;
    bit stall_now;
    mode = 0;
    mode_left = 0;
    phase = 0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      phase++;
      case (mode)
        0: stall_now = 1'b0;
        1: stall_now = ($urandom_range(0, 3) == 0);
        2: stall_now = ($urandom_range(0, 3) != 0);
        default: stall_now = ((phase % 8) < 5);
      endcase
      if (stall_now && stall_run >= StallCap) stall_now = 1'b0;
      stall_run = stall_now ? stall_run + 1 : 0;
      out_stall = stall_now;
    end
  end

  task automatic put_byte(arlc_pkg::char_t b, bit pin, arlc_pkg::line_class_t cls,
                          logic ovf);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_rx_byte = b;
    pin_on = pin;
    pinned.cls = cls;
    pinned.ovf = ovf;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic add_row(string text, int pad_n, arlc_pkg::char_t pad_c, bit typed,
                         arlc_pkg::line_class_t cls, logic ovf);
    line_row_t r;
    r.text = text;
    r.pad_n = pad_n;
    r.pad_c = pad_c;
    r.typed = typed;
    r.cls = cls;
    r.ovf = ovf;
    dir_rows.push_back(r);
  endtask

  function automatic arlc_pkg::char_t noise_char();
    string alpha = "OKGTWIFDSCNPE ,+:";
    arlc_pkg::char_t c;
    case ($urandom_range(0, 3))
      0, 1: c = arlc_pkg::char_t'(alpha[$urandom_range(0, alpha.len() - 1)]);
      2: c = arlc_pkg::char_t'($urandom_range(32, 126));
      default: begin
        c = arlc_pkg::char_t'($urandom_range(0, 255));
        if (c == arlc_pkg::ChLf) c = 8'hFF;
      end
    endcase
    return c;
  endfunction

  task automatic random_line(output arlc_pkg::char_t q[$]);
    int k;
    int n;
    int cut;
    int cr_at;
    q = {};
    if ($urandom_range(0, 19) == 0)
      repeat ($urandom_range(100, 220)) q.push_back(noise_char());
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) q.push_back(noise_char());
        3, 4, 5, 6: begin
          k = $urandom_range(0, arlc_pkg::NumKw - 1);
          n = kw_text[k].len();
          cr_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            if (i == cr_at) q.push_back(arlc_pkg::ChCr);
            q.push_back(arlc_pkg::char_t'(kw_text[k][i]));
          end
        end
        7: begin
          k = $urandom_range(0, arlc_pkg::NumKw - 1);
          cut = $urandom_range(1, kw_text[k].len() - 1);
          for (int i = 0; i < cut; i++) q.push_back(arlc_pkg::char_t'(kw_text[k][i]));
        end
        8: q.push_back(arlc_pkg::ChCr);
        default: q.push_back(arlc_pkg::char_t'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) q.push_back(arlc_pkg::ChCr);
    q.push_back(arlc_pkg::ChLf);
  endtask

  initial begin
    arlc_pkg::char_t q[$];
    int rand_words;
    arlc_pkg::char_t b;
    kw_text[arlc_pkg::KwOk] = "OK";
    kw_text[arlc_pkg::KwGot] = "GOT";
    kw_text[arlc_pkg::KwWifi] = "WIFI DISCONNECT";
    kw_text[arlc_pkg::KwConn] = "CONNECT";
    kw_text[arlc_pkg::KwIpd] = "IPD";
    clear_line();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    active = 1'b1;

    add_row("\n", 0, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("OK\015\n", 0, "x", 1, arlc_pkg::CLS_OK, 1'b0);
    add_row("WIFI GOT IP\015\n", 0, "x", 1, arlc_pkg::CLS_GOT, 1'b0);
    add_row("WIFI DISCONNECT\015\n", 0, "x", 1, arlc_pkg::CLS_WIFI, 1'b0);
    add_row("0,CONNECT\015\n", 0, "x", 1, arlc_pkg::CLS_CONN, 1'b0);
    add_row("+IPD,4:abcd\015\n", 0, "x", 1, arlc_pkg::CLS_IPD, 1'b0);
    add_row("O\015K\n", 0, "x", 1, arlc_pkg::CLS_OK, 1'b0);
    add_row("WIFI DIS\015\015CONNECT\n", 0, "x", 1, arlc_pkg::CLS_WIFI, 1'b0);
    add_row("O\nK\n", 0, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("\n", arlc_pkg::LineMax, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("\n", arlc_pkg::LineMax + 1, "x", 1, arlc_pkg::CLS_WAIT, 1'b1);
    add_row("OK\n", 200, "x", 1, arlc_pkg::CLS_OK, 1'b1);
    add_row("OK\n", 3, 8'h00, 1, arlc_pkg::CLS_OK, 1'b0);
    add_row("\n", 4, 8'hFF, 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("GOT\015OK\015IPD\n", 0, "x", 1, arlc_pkg::CLS_GOT, 1'b0);
    add_row("OK IPD CONNECT\n", 0, "x", 1, arlc_pkg::CLS_OK, 1'b0);
    add_row("CONNECT IPD\n", 0, "x", 1, arlc_pkg::CLS_CONN, 1'b0);
    add_row("WIFI DISCONNEC\n", 0, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("\015\015\015\n", 0, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("ok\n", 0, "x", 1, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("XWIFI DISCONNECTIPD\015\n", 0, "x", 0, arlc_pkg::CLS_WAIT, 1'b0);
    add_row("GO\015T IP CONNEC\n", 0, 8'h80, 0, arlc_pkg::CLS_WAIT, 1'b0);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].pad_n)
        put_byte(dir_rows[r].pad_c, 1'b0, arlc_pkg::CLS_WAIT, 1'b0);
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        b = arlc_pkg::char_t'(dir_rows[r].text[i]);
        put_byte(b, dir_rows[r].typed && b == arlc_pkg::ChLf, dir_rows[r].cls,
                 dir_rows[r].ovf);
      end
    end

    rand_words = 0;
    while (rand_words < RandWords) begin
      random_line(q);
      foreach (q[i]) begin
        put_byte(q[i], 1'b0, arlc_pkg::CLS_WAIT, 1'b0);
        if (q[i] != arlc_pkg::ChCr) rand_words++;
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    pin_on = 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d words and %0d line results, %0d of them overflowed",
             words_taken, lines_checked, ovf_lines);
    $display("line classes wait/ok/got/wifi/connect/ipd: %0d/%0d/%0d/%0d/%0d/%0d",
             class_seen[0], class_seen[1], class_seen[2], class_seen[3],
             class_seen[4], class_seen[5]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/arlc_pkg.sv
rtl/core/arlc_match.sv
rtl/core/arlc_line.sv
rtl/core/at_reply_line_classifier.sv
tb/at_reply_line_classifier_tb.sv
